// ===== rtl/twas_pkg.sv =====
`timescale 1ns / 1ps

package twas_pkg;

  // Store geometry
  localparam int DEPTH  = 64;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SLOT_W = CNT_W + 1;

  // Field widths
  localparam int SAMPLE_W  = 16;
  localparam int TIME_W    = 32;
  localparam int ENTRIES_W = 7;
  localparam int REG_W     = 32;

  // Arithmetic widths: running sum, rounding numerator 2*sum+n, divisor 2*n
  localparam int SUM_W  = SAMPLE_W + $clog2(DEPTH);
  localparam int NUM_W  = SUM_W + 2;
  localparam int DEN_W  = CNT_W + 1;
  localparam int DCNT_W = $clog2(NUM_W + 1);

  // Configuration port
  localparam int PADDR_W = 3;
  localparam logic [REG_W-1:0] WINDOW_RESET = 32'd1000;
  localparam logic [REG_W-1:0] JUMP_RESET   = 32'd0;

  typedef enum logic {
    REG_WINDOW = 1'b0,
    REG_JUMP   = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [REG_W-1:0] window_ms;
    logic [REG_W-1:0] jump_threshold;
  } cfg_regs_t;

endpackage

// ===== rtl/twas_if.sv =====
`timescale 1ns / 1ps

// Input channel: one sample with its timestamp
interface twas_in_if import twas_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic [TIME_W-1:0]   timestamp_ms;

  modport source (output valid, output sample, output timestamp_ms, input ready);
  modport sink   (input valid, input sample, input timestamp_ms, output ready);
endinterface

// Result channel: window average and status
interface twas_out_if import twas_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [SAMPLE_W-1:0]  average;
  logic [ENTRIES_W-1:0] entries;
  logic                 window_cleared;
  logic                 overflow_evicted;

  modport source (output valid, output average, output entries,
                  output window_cleared, output overflow_evicted, input ready);
  modport sink   (input valid, input average, input entries,
                  input window_cleared, input overflow_evicted, output ready);
endinterface

// ===== rtl/twas_cfg.sv =====
`timescale 1ns / 1ps

module twas_cfg import twas_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [REG_W-1:0]   pwdata,
  output logic [REG_W-1:0]   prdata,
  output logic               pready,
  output cfg_regs_t          regs
);

  logic [REG_W-1:0] window_r;
  logic [REG_W-1:0] jump_r;
  logic             wr_en;
  reg_idx_t         idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[2]);

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
      jump_r   <= JUMP_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_WINDOW: window_r <= pwdata;
        REG_JUMP:   jump_r   <= pwdata;
        default: ;
      endcase
    end
  end

  // Readback
  always_comb begin
    unique case (idx)
      REG_WINDOW: prdata = window_r;
      REG_JUMP:   prdata = jump_r;
      default:    prdata = '0;
    endcase
  end

  assign regs.window_ms      = window_r;
  assign regs.jump_threshold = jump_r;

endmodule

// ===== rtl/twas_store.sv =====
`timescale 1ns / 1ps

module twas_store import twas_pkg::*; (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  logic [SAMPLE_W-1:0] wr_sample,
  input  logic [TIME_W-1:0]   wr_time,
  input  logic [ADDR_W-1:0]   rd_addr,
  output logic [SAMPLE_W-1:0] rd_sample,
  output logic [TIME_W-1:0]   rd_time
);

  logic [SAMPLE_W-1:0] sample_mem [DEPTH];
  logic [TIME_W-1:0]   time_mem   [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      sample_mem[wr_addr] <= wr_sample;
      time_mem[wr_addr]   <= wr_time;
    end
    rd_sample <= sample_mem[rd_addr];
    rd_time   <= time_mem[rd_addr];
  end

endmodule

// ===== rtl/twas_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle
module twas_div import twas_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  logic [NUM_W-1:0]  num_r, num_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [DEN_W-1:0]  den_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DEN_W:0]    trial;
  logic              ge;

  // Shift in next numerator bit, subtract when it fits
  always_comb begin
    trial   = {rem_r, num_r[NUM_W-1]};
    ge      = trial >= {1'b0, den_r};
    rem_nxt = ge ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
    num_nxt = {num_r[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DCNT_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quot = num_r;

endmodule

// ===== rtl/time_window_average_smoother.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Payload                                              Transfer
// in_chan   in   sample[15:0], timestamp_ms[31:0]                     valid & ready
// out_chan  out  average[15:0], entries[6:0], window_cleared,         valid & ready
//                overflow_evicted
// psel..    APB  window_ms at 0x0, jump_threshold at 0x4              psel & penable & pwrite
//
// After transfer an item runs the jump check, then a store read and age compare per
// entry aged out (0..DEPTH), the compare skipped when the window is empty before the
// append; then the append, the divide start, the 24-step bit-serial rounding divide
// and its done strobe, then the result load. No clearing pass after reset; the
// store is tracked by its oldest index and fill count. in_chan.ready is high only
// while idle; a new item may be taken while the previous result still waits on
// out_chan.
module time_window_average_smoother import twas_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  twas_in_if.sink            in_chan,
  twas_out_if.source         out_chan,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [REG_W-1:0]   pwdata,
  output logic [REG_W-1:0]   prdata,
  output logic               pready
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_JUMP  = 8'b0000_0010,
    S_READ  = 8'b0000_0100,
    S_CHECK = 8'b0000_1000,
    S_WRITE = 8'b0001_0000,
    S_DIVGO = 8'b0010_0000,
    S_DIVW  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  cfg_regs_t regs;

  logic [SAMPLE_W-1:0]  sample_r;
  logic [TIME_W-1:0]    now_r;
  logic [ADDR_W-1:0]    oldest_r, oldest_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [SAMPLE_W-1:0]  avg_r;
  logic                 cleared_r, cleared_nxt;
  logic                 ovf_r, ovf_nxt;

  logic                 out_valid_r;
  logic [SAMPLE_W-1:0]  out_avg_r;
  logic [ENTRIES_W-1:0] out_entries_r;
  logic                 out_cleared_r;
  logic                 out_ovf_r;

  logic [SAMPLE_W-1:0]  rd_sample;
  logic [TIME_W-1:0]    rd_time;
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  logic [SLOT_W-1:0]    slot_sum;

  logic [SAMPLE_W-1:0]  deviation;
  logic [TIME_W-1:0]    age;
  logic [ADDR_W-1:0]    oldest_inc;
  logic                 div_start;
  logic                 div_done;
  logic [NUM_W-1:0]     div_num;
  logic [DEN_W-1:0]     div_den;
  logic [NUM_W-1:0]     div_quot;
  logic                 in_xfer;
  logic                 out_load;

  twas_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .regs    (regs)
  );

  twas_store u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_sample (sample_r),
    .wr_time   (now_r),
    .rd_addr   (oldest_r),
    .rd_sample (rd_sample),
    .rd_time   (rd_time)
  );

  twas_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_xfer       = in_chan.valid && (state_r == S_IDLE);

  // Distance from previous average, wrapped age of oldest entry
  assign deviation  = (avg_r > sample_r) ? (avg_r - sample_r) : (sample_r - avg_r);
  assign age        = now_r - rd_time;
  assign oldest_inc = (oldest_r == ADDR_W'(DEPTH - 1)) ? '0 : oldest_r + 1'b1;

  // Append slot = oldest + count, wrapped
  always_comb begin
    slot_sum = SLOT_W'(oldest_r) + SLOT_W'(count_r);
    if (slot_sum >= SLOT_W'(DEPTH)) begin
      slot_sum = slot_sum - SLOT_W'(DEPTH);
    end
  end
  assign wr_addr = slot_sum[ADDR_W-1:0];
  assign wr_en   = (state_r == S_WRITE);

  // Rounding divide operands: (2*sum + n) / (2*n)
  assign div_num   = {1'b0, sum_r, 1'b0} + NUM_W'(count_r);
  assign div_den   = {count_r, 1'b0};
  assign div_start = (state_r == S_DIVGO);

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_chan.ready);

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    oldest_nxt  = oldest_r;
    count_nxt   = count_r;
    sum_nxt     = sum_r;
    cleared_nxt = cleared_r;
    ovf_nxt     = ovf_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          cleared_nxt = 1'b0;
          ovf_nxt     = 1'b0;
          state_nxt   = S_JUMP;
        end
      end
      S_JUMP: begin
        if ((regs.jump_threshold != '0) &&
            (REG_W'(deviation) > regs.jump_threshold)) begin
          count_nxt   = '0;
          sum_nxt     = '0;
          cleared_nxt = 1'b1;
        end
        state_nxt = S_READ;
      end
      S_READ: begin
        state_nxt = (count_r == '0) ? S_WRITE : S_CHECK;
      end
      S_CHECK: begin
        if (age > regs.window_ms) begin
          sum_nxt    = sum_r - SUM_W'(rd_sample);
          oldest_nxt = oldest_inc;
          count_nxt  = count_r - 1'b1;
          state_nxt  = S_READ;
        end else if (count_r == CNT_W'(DEPTH)) begin
          sum_nxt    = sum_r - SUM_W'(rd_sample);
          oldest_nxt = oldest_inc;
          count_nxt  = count_r - 1'b1;
          ovf_nxt    = 1'b1;
          state_nxt  = S_WRITE;
        end else begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        count_nxt = count_r + 1'b1;
        sum_nxt   = sum_r + SUM_W'(sample_r);
        state_nxt = S_DIVGO;
      end
      S_DIVGO: begin
        state_nxt = S_DIVW;
      end
      S_DIVW: begin
        if (div_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      oldest_r    <= '0;
      count_r     <= '0;
      sum_r       <= '0;
      avg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      oldest_r <= oldest_nxt;
      count_r  <= count_nxt;
      sum_r    <= sum_nxt;
      if ((state_r == S_DIVW) && div_done) begin
        avg_r <= SAMPLE_W'(div_quot);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item and result payload
  always_ff @(posedge clk) begin
    cleared_r <= cleared_nxt;
    ovf_r     <= ovf_nxt;
    if (in_xfer) begin
      sample_r <= in_chan.sample;
      now_r    <= in_chan.timestamp_ms;
    end
    if (out_load) begin
      out_avg_r     <= avg_r;
      out_entries_r <= ENTRIES_W'(count_r);
      out_cleared_r <= cleared_r;
      out_ovf_r     <= ovf_r;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.average          = out_avg_r;
  assign out_chan.entries          = out_entries_r;
  assign out_chan.window_cleared   = out_cleared_r;
  assign out_chan.overflow_evicted = out_ovf_r;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import twas_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 200;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [TIME_W-1:0]   timestamp_ms;
  } reading_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0]  average;
    logic [ENTRIES_W-1:0] entries;
    logic                 window_cleared;
    logic                 overflow_evicted;
  } window_result_t;

  logic               clk     = 1'b0;
  logic               rst_n   = 1'b0;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [REG_W-1:0]   pwdata  = '0;
  logic [REG_W-1:0]   prdata;
  logic               pready;

  twas_in_if  in_if ();
  twas_out_if out_if ();

  time_window_average_smoother DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // 50 MHz clock
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Window model: sample/time FIFO with running sum, plus register copies
  logic [SAMPLE_W-1:0] win_samples [DEPTH];
  logic [TIME_W-1:0]   win_times   [DEPTH];
  int unsigned         head_idx = 0;
  int unsigned         fill     = 0;
  longint unsigned     win_sum  = 0;
  logic [REG_W-1:0]    win_len  = WINDOW_RESET;
  logic [REG_W-1:0]    jump_thr = JUMP_RESET;

  reading_t       reading_q [$];
  window_result_t expected_q [$];

  bit          in_fire;
  int          in_idle_pct  = 12;
  int          out_idle_pct = 12;
  int          stall_reqs   = 0;
  int          stall_served = 0;
  int          stall_left   = 0;
  int          items_queued = 0;
  int          results_seen = 0;
  int          errors       = 0;
  int unsigned cycle_count  = 0;
  logic [TIME_W-1:0] clock_ms = '0;

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  // Rounded-half-up mean; empty window reads as zero
  function automatic logic [31:0] window_mean();
    if (fill == 0) return '0;
    return 32'((2 * win_sum + fill) / (2 * fill));
  endfunction

  function automatic void drop_oldest();
    win_sum  -= win_samples[head_idx];
    head_idx  = (head_idx + 1) % DEPTH;
    fill--;
  endfunction

  // Apply one sample to the window and return the result it produces
  function automatic window_result_t advance_window(input logic [SAMPLE_W-1:0] smp,
                                                    input logic [TIME_W-1:0] now);
    window_result_t    r;
    logic [31:0]       prev;
    logic [31:0]       deviation;
    logic [TIME_W-1:0] age;
    int unsigned       slot;
    r = '0;
    // jump check against the mean before this sample
    if (jump_thr != 0) begin
      prev = window_mean();
      deviation = (prev > smp) ? prev - smp : smp - prev;
      if (deviation > jump_thr) begin
        fill    = 0;
        win_sum = 0;
        r.window_cleared = 1'b1;
      end
    end
    // age eviction, ages wrap mod 2^32; age equal to the window is kept
    while (fill > 0) begin
      age = now - win_times[head_idx];
      if (age <= win_len) break;
      drop_oldest();
    end
    if (fill >= DEPTH) begin
      drop_oldest();
      r.overflow_evicted = 1'b1;
    end
    slot = (head_idx + fill) % DEPTH;
    win_samples[slot] = smp;
    win_times[slot]   = now;
    fill++;
    win_sum += smp;
    r.average = SAMPLE_W'(window_mean());
    r.entries = ENTRIES_W'(fill);
    return r;
  endfunction

  // Input driver: present the next reading once the current one transferred
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_fire) begin
      if (reading_q.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
        in_if.valid        <= 1'b1;
        in_if.sample       <= reading_q[0].sample;
        in_if.timestamp_ms <= reading_q[0].timestamp_ms;
        void'(reading_q.pop_front());
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result-side ready: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if (stall_served != stall_reqs) begin
      stall_served = stall_reqs;
      stall_left   = HOLD_CYCLES - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Monitor: predict on input transfer, compare on result transfer
  always @(posedge clk) begin
    window_result_t want;
    in_fire = rst_n && in_if.valid && in_if.ready;
    if (in_fire)
      expected_q.insert(expected_q.size(), advance_window(in_if.sample, in_if.timestamp_ms));
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("result transfer with no expected result");
      end else begin
        want = expected_q.pop_front();
        if (out_if.average !== want.average)
          report_mismatch($sformatf("average: got %0d, expected %0d",
                                    out_if.average, want.average));
        if (out_if.entries !== want.entries)
          report_mismatch($sformatf("entries: got %0d, expected %0d",
                                    out_if.entries, want.entries));
        if (out_if.window_cleared !== want.window_cleared)
          report_mismatch($sformatf("window_cleared: got %0b, expected %0b",
                                    out_if.window_cleared, want.window_cleared));
        if (out_if.overflow_evicted !== want.overflow_evicted)
          report_mismatch($sformatf("overflow_evicted: got %0b, expected %0b",
                                    out_if.overflow_evicted, want.overflow_evicted));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Register write followed by a read-back
  task automatic write_reg(input reg_idx_t idx, input logic [REG_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_WINDOW: win_len  = value;
      REG_JUMP:   jump_thr = value;
    endcase
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== value)
      report_mismatch($sformatf("register %s read back %0h, wrote %0h",
                                idx.name(), prdata, value));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic add_reading(input logic [SAMPLE_W-1:0] smp, input logic [TIME_W-1:0] ts);
    reading_t rd;
    rd.sample       = smp;
    rd.timestamp_ms = ts;
    reading_q.insert(reading_q.size(), rd);
    clock_ms = ts;
    items_queued++;
  endtask

  task automatic wait_all_results();
    while (results_seen != items_queued) @(negedge clk);
  endtask

  // Readings around a wandering level, with level jumps, extremes, noise,
  // random time gaps and steps landing right at the window edge
  task automatic queue_phase(input int count, input int max_step, input int gap_pct);
    int                level;
    int                smp;
    int                pick;
    logic [TIME_W-1:0] step;
    level = $urandom_range(65535);
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        smp = $urandom_range(1) ? 65535 : 0;
      end else if (pick < 10) begin
        level = $urandom_range(65535);
        smp   = level;
      end else if (pick < 15) begin
        smp = $urandom_range(65535);
      end else begin
        smp = level + int'($urandom_range(64)) - 32;
        if (smp < 0) smp = 0;
        else if (smp > 65535) smp = 65535;
      end
      pick = $urandom_range(99);
      if (pick < gap_pct / 2)
        step = $urandom();
      else if (pick < gap_pct)
        step = win_len + $urandom_range(2) - 1;
      else
        step = $urandom_range(max_step);
      add_reading(smp[SAMPLE_W-1:0], clock_ms + step);
    end
  endtask

  // Stimulus sequence
  initial begin
    in_if.valid        = 1'b0;
    in_if.sample       = '0;
    in_if.timestamp_ms = '0;
    out_if.ready       = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // jump check, including a jump on the empty window right after reset
    write_reg(REG_JUMP, 32'd100);
    add_reading(16'hFFFF, 32'd0);
    add_reading(16'h0000, 32'd0);
    add_reading(16'd100, 32'd1);
    add_reading(16'd151, 32'd2);
    wait_all_results();

    // age boundary, rounding, wrap-around and full eviction
    write_reg(REG_JUMP, 32'd0);
    write_reg(REG_WINDOW, 32'd1000);
    add_reading(16'd1, 32'd10);
    add_reading(16'd2, 32'd20);
    add_reading(16'd3, 32'd1010);
    add_reading(16'd4, 32'd1011);
    add_reading(16'hFFFF, 32'hFFFF_FFF0);
    add_reading(16'h0000, 32'd5);
    add_reading(16'd7, 32'd10005);
    wait_all_results();

    // zero-length window keeps only equal timestamps
    write_reg(REG_WINDOW, 32'd0);
    add_reading(16'd5, 32'd20000);
    add_reading(16'd6, 32'd20000);
    add_reading(16'd7, 32'd20001);
    wait_all_results();

    // widest window and threshold
    write_reg(REG_WINDOW, 32'hFFFF_FFFF);
    write_reg(REG_JUMP, 32'hFFFF_FFFF);
    add_reading(16'h8000, 32'd0);
    add_reading(16'h7FFF, 32'h8000_0000);
    add_reading(16'hFFFF, 32'hFFFF_FFFF);

    // random phases over several register settings
    for (int p = 0; p < 8; p++) begin
      wait_all_results();
      case (p)
        0: begin
          write_reg(REG_WINDOW, 32'd1000);
          write_reg(REG_JUMP, 32'd0);
          queue_phase(225, 40, 5);
        end
        1: begin
          // store stays full; result side holds off while readings keep coming
          write_reg(REG_WINDOW, 32'hFFFF_FFFF);
          write_reg(REG_JUMP, 32'hFFFF_FFFF);
          queue_phase(225, 1000, 10);
          stall_reqs++;
        end
        2: begin
          write_reg(REG_WINDOW, 32'd0);
          write_reg(REG_JUMP, 32'd0);
          queue_phase(225, 1, 10);
        end
        3: begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
          write_reg(REG_WINDOW, 32'd200);
          write_reg(REG_JUMP, 32'd2000);
          queue_phase(225, 20, 5);
        end
        4: begin
          in_idle_pct  = 12;
          out_idle_pct = 12;
          write_reg(REG_WINDOW, $urandom());
          write_reg(REG_JUMP, 32'd1);
          clock_ms = 32'hFFFF_FF00;
          queue_phase(225, 50, 10);
        end
        5: begin
          write_reg(REG_WINDOW, 32'd5000);
          write_reg(REG_JUMP, $urandom_range(65535, 1));
          queue_phase(110, 100, 8);
          wait_all_results();
          queue_phase(115, 100, 8);
        end
        6: begin
          write_reg(REG_WINDOW, $urandom_range(500));
          write_reg(REG_JUMP, 32'd0);
          queue_phase(225, 30, 50);
        end
        default: begin
          write_reg(REG_WINDOW, WINDOW_RESET);
          write_reg(REG_JUMP, JUMP_RESET);
          queue_phase(225, 30, 5);
        end
      endcase
    end

    wait_all_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (errors == 0 && expected_q.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/twas_pkg.sv
rtl/twas_if.sv
rtl/twas_cfg.sv
rtl/twas_store.sv
rtl/twas_div.sv
rtl/time_window_average_smoother.sv
verif/tb_top.sv
